/* hw/rtl/fpls_pkg.sv */
// Shared types, codes and format conversion functions of the FP load/store unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
package fpls_pkg;

  localparam int unsigned InTdataW  = 224;
  localparam int unsigned OutTdataW = 280;

  typedef enum logic [2:0] {
    MEM_NONE     = 3'd0,
    MEM_READ_W   = 3'd1,
    MEM_READ_DW  = 3'd2,
    MEM_WRITE_W  = 3'd3,
    MEM_WRITE_DW = 3'd4
  } mem_req_t;

  typedef enum logic [0:0] {
    ACT_ISSUE    = 1'b0,
    ACT_RESPONSE = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    CFG_FP_ENABLE = 1'b0,
    CFG_PS_ENABLE = 1'b1
  } cfg_idx_t;

  localparam logic [4:0] OP_STFIWX  = 5'd16;
  localparam logic [4:0] OP_FIRST_STORE = 5'd8;
  localparam logic [63:0] LowWord   = 64'h0000_0000_ffff_ffff;

  // One classified beat passed from the front to the back.
  typedef struct packed {
    mem_req_t    mem_request;
    logic [31:0] address;
    logic        fp_unavailable;
    logic        round_single;   // data holds a double to round for a single store
    logic        store_raw;      // data is the store data as is
    logic [63:0] data;           // source bits or read data
    logic        load_write;
    logic        load_double;
    logic        ps_enable;
    logic [4:0]  fpr_dest;
    logic        gpr_update;
    logic [4:0]  gpr_dest;
    logic [31:0] gpr_value;
  } fpls_op_t;

  function automatic logic [31:0] dbl_to_single(input logic [63:0] b);
    logic [31:0]        sgn;
    logic [10:0]        e;
    logic [51:0]        m;
    logic signed [12:0] es;
    logic [63:0]        sig;
    logic [12:0]        shift;
    logic [63:0]        q;
    logic [63:0]        rem;
    logic [63:0]        half;
    logic [63:0]        val;
    logic [31:0]        res;
    sgn = {b[63], 31'd0};
    e   = b[62:52];
    m   = b[51:0];
    es  = $signed({2'b00, e}) - 13'sd896;
    sig = {11'd0, 1'b1, m};
    shift = (es >= 13'sd1) ? 13'd29 : 13'(13'sd30 - es);
    q = '0; rem = '0; half = '0; val = '0;
    if (e == 11'h7ff) begin
      res = (m != '0) ? (sgn | 32'h7fc0_0000 | {9'd0, m[51:29]}) : (sgn | 32'h7f80_0000);
    end else if (e == 11'd0) begin
      res = sgn;
    end else if (es >= 13'sd255) begin
      res = sgn | 32'h7f80_0000;
    end else if (shift > 13'd62) begin
      res = sgn;
    end else begin
      // The halfway point can lie above the significand for deep denormals.
      q    = sig >> shift[5:0];
      half = 64'd1 << (shift[5:0] - 6'd1);
      rem  = sig & ((half << 1) - 64'd1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (es >= 13'sd1) begin
        val = (({51'd0, es} - 64'd1) << 23) + q;
        res = (val >= 64'h7f80_0000) ? (sgn | 32'h7f80_0000) : (sgn | val[31:0]);
      end else begin
        res = sgn | q[31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] single_to_dbl(input logic [31:0] w);
    logic [7:0]  e8;
    logic [22:0] m;
    logic [4:0]  p;
    logic [4:0]  k;
    logic [22:0] mn;
    logic [10:0] ex;
    logic [63:0] res;
    e8 = w[30:23];
    m  = w[22:0];
    p  = '0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) p = 5'(i);
    end
    k  = 5'd23 - p;
    mn = m << k;
    ex = 11'd897 - {6'd0, k};
    if (e8 == 8'hff) begin
      res = {w[31], 11'h7ff, m, 29'd0};
    end else if (e8 == 8'd0) begin
      res = (m == '0) ? {w[31], 63'd0} : {w[31], ex, mn, 29'd0};
    end else begin
      res = {w[31], 11'({3'd0, e8} + 11'd896), m, 29'd0};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/fp_load_store_unit.sv */
// Top level of the floating-point load/store unit: front, queue and back.
// Depends on fpls_pkg, fpls_front, fpls_queue and fpls_back.
//
//  Channel  | Direction | Signals
//  ---------+-----------+-----------------------------------------------
//  in_      | input     | tvalid/tready, tuser = action, tdata = fields
//  out_     | output    | tvalid/tready, tdata = result fields
//  cfg_     | input     | wr_en, index, wdata (write only)
//
// One beat is accepted per cycle while the two-entry queue has room.
// A result passes through the queue, then the output register, where the
// format conversion lands.
// A stalled output fills the queue, after which in_tready drops.
// Reset is synchronous and clears the pending access and the queue.
module fp_load_store_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // action
  input  logic                            in_tuser,
  // opcode, ra_index, ra_value, rb_value, displacement, fpr_index,
  // source_bits, read_data, access_fault
  input  logic [fpls_pkg::InTdataW-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // mem_request, address, store_data, fp_unavailable, fpr_write, ps1_write,
  // fpr_dest, ps0_bits, ps1_bits, gpr_update, gpr_dest, gpr_value, zero pad
  output logic [fpls_pkg::OutTdataW-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic                            cfg_wdata
);
  import fpls_pkg::*;

  logic     fp_en_r, ps_en_r, accept, q_not_full, q_not_empty, q_pop;
  fpls_op_t front_op, head_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_en_r <= 1'b0;
      ps_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FP_ENABLE: fp_en_r <= cfg_wdata;
        CFG_PS_ENABLE: ps_en_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = q_not_full;
  assign accept    = in_tvalid && q_not_full;

  fpls_front u_front (
    .clk, .rst_n,
    .cfg_fp_enable(fp_en_r), .cfg_ps_enable(ps_en_r),
    .accept, .action(in_tuser), .tdata(in_tdata), .op(front_op)
  );

  fpls_queue u_queue (
    .clk, .rst_n,
    .push(accept), .push_op(front_op), .not_full(q_not_full),
    .pop(q_pop), .not_empty(q_not_empty), .head_op
  );

  fpls_back u_back (
    .clk, .rst_n,
    .q_not_empty, .q_head(head_op), .q_pop,
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule

/* hw/rtl/fpls_front.sv */
// Front end: accepts beats, decodes opcodes, forms the effective address and
// tracks the pending access. Depends on fpls_pkg.
module fpls_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_fp_enable,
  input  logic                            cfg_ps_enable,
  input  logic                            accept,
  input  logic                            action,
  input  logic [fpls_pkg::InTdataW-1:0]   tdata,
  output fpls_pkg::fpls_op_t              op
);
  import fpls_pkg::*;

  logic        pend_valid_r, pend_valid_nxt;
  logic [4:0]  pend_opcode_r, pend_opcode_nxt;
  logic [4:0]  pend_fpr_r, pend_fpr_nxt;
  logic [4:0]  pend_base_r, pend_base_nxt;
  logic [31:0] pend_addr_r, pend_addr_nxt;

  logic [4:0]  opcode, ra_index, fpr_index;
  logic [31:0] ra_value, rb_value, disp_ext, base, ea;
  logic [63:0] source_bits, read_data;
  logic        access_fault, is_store, is_dbl, is_upd, is_idx;

  assign opcode       = tdata[4:0];
  assign ra_index     = tdata[9:5];
  assign ra_value     = tdata[41:10];
  assign rb_value     = tdata[73:42];
  assign disp_ext     = {{16{tdata[89]}}, tdata[89:74]};
  assign fpr_index    = tdata[94:90];
  assign source_bits  = tdata[158:95];
  assign read_data    = tdata[222:159];
  assign access_fault = tdata[223];

  always_comb begin
    if (opcode == OP_STFIWX) begin
      is_store = 1'b1; is_dbl = 1'b0; is_upd = 1'b0; is_idx = 1'b1;
    end else begin
      is_store = opcode[3]; is_dbl = opcode[2]; is_upd = opcode[1]; is_idx = opcode[0];
    end
    base = (is_upd || ra_index != 5'd0) ? ra_value : 32'd0;
    ea   = base + (is_idx ? rb_value : disp_ext);
  end

  always_comb begin
    op = '0;
    op.mem_request = MEM_NONE;
    pend_valid_nxt  = pend_valid_r;
    pend_opcode_nxt = pend_opcode_r;
    pend_fpr_nxt    = pend_fpr_r;
    pend_base_nxt   = pend_base_r;
    pend_addr_nxt   = pend_addr_r;
    if (action == ACT_ISSUE) begin
      pend_valid_nxt = 1'b0;
      if (opcode <= OP_STFIWX) begin
        if (!cfg_fp_enable) begin
          op.fp_unavailable = 1'b1;
        end else begin
          op.address = ea;
          if (is_store) begin
            op.mem_request  = is_dbl ? MEM_WRITE_DW : MEM_WRITE_W;
            op.round_single = !is_dbl && opcode != OP_STFIWX;
            op.store_raw    = is_dbl || opcode == OP_STFIWX;
            op.data         = (opcode == OP_STFIWX) ? (source_bits & LowWord) : source_bits;
          end else begin
            op.mem_request = is_dbl ? MEM_READ_DW : MEM_READ_W;
          end
          pend_valid_nxt  = 1'b1;
          pend_opcode_nxt = opcode;
          pend_fpr_nxt    = fpr_index;
          pend_base_nxt   = ra_index;
          pend_addr_nxt   = ea;
        end
      end
    end else if (pend_valid_r) begin
      pend_valid_nxt = 1'b0;
      if (!access_fault) begin
        if (pend_opcode_r < OP_FIRST_STORE) begin
          op.load_write  = 1'b1;
          op.load_double = pend_opcode_r[2];
          op.ps_enable   = cfg_ps_enable;
          op.fpr_dest    = pend_fpr_r;
          op.data        = read_data;
        end
        if (pend_opcode_r < OP_STFIWX && pend_opcode_r[1]) begin
          op.gpr_update = 1'b1;
          op.gpr_dest   = pend_base_r;
          op.gpr_value  = pend_addr_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r  <= 1'b0;
      pend_opcode_r <= '0;
      pend_fpr_r    <= '0;
      pend_base_r   <= '0;
      pend_addr_r   <= '0;
    end else if (accept) begin
      pend_valid_r  <= pend_valid_nxt;
      pend_opcode_r <= pend_opcode_nxt;
      pend_fpr_r    <= pend_fpr_nxt;
      pend_base_r   <= pend_base_nxt;
      pend_addr_r   <= pend_addr_nxt;
    end
  end

endmodule

/* hw/rtl/fpls_queue.sv */
// Two-entry queue of decoded operations between the front and the back.
// Depends on fpls_pkg.
module fpls_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fpls_pkg::fpls_op_t push_op,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output fpls_pkg::fpls_op_t head_op
);
  import fpls_pkg::*;

  fpls_op_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign not_full  = count_r != 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head_op   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hw/rtl/fpls_back.sv */
// Back end: converts formats (single rounding, single widening) and holds the
// result beat in the output register. Depends on fpls_pkg.
module fpls_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_not_empty,
  input  fpls_pkg::fpls_op_t             q_head,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fpls_pkg::OutTdataW-1:0] out_tdata
);
  import fpls_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [OutTdataW-1:0] data_r, data_nxt;
  logic [63:0]          store_data, wide, ps0, ps1;

  assign q_pop = q_not_empty && (!valid_r || out_tready);

  always_comb begin
    wide = single_to_dbl(q_head.data[31:0]);
    if (q_head.round_single)   store_data = {32'd0, dbl_to_single(q_head.data)};
    else if (q_head.store_raw) store_data = q_head.data;
    else                       store_data = '0;
    ps0 = '0;
    ps1 = '0;
    if (q_head.load_write) begin
      ps0 = q_head.load_double ? q_head.data : wide;
      if (!q_head.load_double && q_head.ps_enable) ps1 = wide;
    end
    data_nxt = {7'd0, q_head.gpr_value, q_head.gpr_dest, q_head.gpr_update, ps1, ps0,
                q_head.fpr_dest, q_head.load_write && !q_head.load_double && q_head.ps_enable,
                q_head.load_write, q_head.fp_unavailable, store_data, q_head.address,
                q_head.mem_request};
    valid_nxt = q_pop || (valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

/* hw/rtl/fpls_checker.sv */
// Port-level checker for the FP load/store unit, bound to the top level.
// Depends on fp_load_store_unit and fpls_pkg.
module fpls_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fpls_pkg::OutTdataW-1:0] out_tdata
);
  import fpls_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  a_unavail_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[99] |-> out_tdata[2:0] == MEM_NONE)
    else $error("FP-unavailable beat carries a memory request");

  a_ps1_needs_fpr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[101] |-> out_tdata[100])
    else $error("ps1 write without primary write");

  a_unavail_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[99] |-> !out_tdata[100] && !out_tdata[235])
    else $error("FP-unavailable beat carries writeback");

endmodule

bind fp_load_store_unit fpls_checker u_fpls_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
